FILE: hdl/pmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned multi-queue package
// Sizes, codes and the command record shared by the front, the command queue
// and the back end of the partitioned multi-queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int TOTAL_SLOTS = 32;
  localparam int QUEUE_COUNT = 4;
  localparam int ITEM_BITS   = 32;
  localparam int SEG_SIZE    = TOTAL_SLOTS / QUEUE_COUNT;
  localparam int MAX_RESULTS = 8;

  localparam int MODE_BITS   = 2;
  localparam int QIDX_BITS   = 2;
  localparam int DATA_BITS   = 32;

  localparam int SLOT_BITS   = $clog2(TOTAL_SLOTS + 1);
  localparam int ADDR_BITS   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int QSEL_BITS   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  localparam int OPQ_DEPTH      = 2;
  localparam int OPQ_PTR_BITS   = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int OPQ_CNT_BITS   = $clog2(OPQ_DEPTH + 1);
  localparam int RESQ_DEPTH     = 4;
  localparam int RESQ_PTR_BITS  = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_BITS  = $clog2(RESQ_DEPTH + 1);

  localparam logic [MODE_BITS-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LIST = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One classified command: a store write, a run of store reads, or a bare
  // status result.
  typedef struct packed {
    status_t                status;
    logic                   wr;
    logic                   rd;
    logic [ADDR_BITS-1:0]   addr;
    logic [CNT_BITS-1:0]    cnt;
    logic [ITEM_BITS-1:0]   data;
  } pmq_op_t;

endpackage
`default_nettype wire

FILE: hdl/pmq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned multi-queue front end
// Accepts commands, holds the head and tail pointers of every queue and turns
// each command but mode 3 into a store operation or a status result for the back end.
// ----------------------------------------------------------------------------
module pmq_front import pmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [QIDX_BITS-1:0] queue_index,
  input  logic [DATA_BITS-1:0] item,
  input  logic                 op_full,
  output logic                 op_push,
  output pmq_op_t              op
);

  logic [SLOT_BITS-1:0] head_pointer [QUEUE_COUNT];
  logic [SLOT_BITS-1:0] tail_pointer [QUEUE_COUNT];

  logic [QSEL_BITS-1:0] q;
  logic                 in_range;
  logic                 accept;
  logic [SLOT_BITS-1:0] h;
  logic [SLOT_BITS-1:0] t;
  logic [SLOT_BITS-1:0] seg_end;
  logic [SLOT_BITS-1:0] fill;
  logic                 enq_ok;
  logic                 deq_ok;

  always_comb begin
    q        = QSEL_BITS'(queue_index);
    in_range = int'(queue_index) < QUEUE_COUNT;
    h        = head_pointer[q];
    t        = tail_pointer[q];
    seg_end  = SLOT_BITS'((int'(q) + 1) * SEG_SIZE);
    fill     = t - h;
    enq_ok   = t < seg_end;
    deq_ok   = t != h;
    accept   = push && !op_full && in_range;

    op        = '0;
    op.status = ST_OK;
    op_push   = 1'b0;
    if (accept) begin
      case (mode)
        MODE_ENQ: begin
          op_push = 1'b1;
          if (enq_ok) begin
            op.wr   = 1'b1;
            op.addr = t[ADDR_BITS-1:0];
            op.data = ITEM_BITS'(item);
          end else begin
            op.status = ST_FULL;
          end
        end
        MODE_DEQ: begin
          op_push = 1'b1;
          if (deq_ok) begin
            op.rd   = 1'b1;
            op.addr = h[ADDR_BITS-1:0];
            op.cnt  = CNT_BITS'(1);
          end else begin
            op.status = ST_EMPTY;
          end
        end
        MODE_LIST: begin
          op_push = 1'b1;
          if (deq_ok) begin
            op.rd   = 1'b1;
            op.addr = h[ADDR_BITS-1:0];
            op.cnt  = (int'(fill) > MAX_RESULTS) ? CNT_BITS'(MAX_RESULTS) : CNT_BITS'(fill);
          end else begin
            op.status = ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_pointer[i] <= SLOT_BITS'(i * SEG_SIZE);
        tail_pointer[i] <= SLOT_BITS'(i * SEG_SIZE);
      end
    end else if (accept) begin
      case (mode)
        MODE_ENQ: begin
          if (enq_ok) begin
            tail_pointer[q] <= t + SLOT_BITS'(1);
          end
        end
        MODE_DEQ: begin
          if (deq_ok) begin
            head_pointer[q] <= h + SLOT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_head_behind_tail: assert property (@(posedge clk) disable iff (rst)
    in_range |-> (h <= t))
    else $error("head pointer passed tail pointer");

  a_tail_in_segment: assert property (@(posedge clk) disable iff (rst)
    in_range |-> (t <= seg_end))
    else $error("tail pointer left its segment");

endmodule
`default_nettype wire

FILE: hdl/pmq_op_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned multi-queue command queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module pmq_op_queue import pmq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  pmq_op_t wr_op,
  output logic    full,
  output logic    valid,
  input  logic    rd_en,
  output pmq_op_t rd_op
);

  pmq_op_t                 entries [OPQ_DEPTH];
  logic [OPQ_PTR_BITS-1:0] wr_ptr;
  logic [OPQ_PTR_BITS-1:0] rd_ptr;
  logic [OPQ_CNT_BITS-1:0] count;

  assign full  = int'(count) == OPQ_DEPTH;
  assign valid = count != '0;
  assign rd_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (int'(wr_ptr) == OPQ_DEPTH - 1) ? '0 : wr_ptr + OPQ_PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= (int'(rd_ptr) == OPQ_DEPTH - 1) ? '0 : rd_ptr + OPQ_PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + OPQ_CNT_BITS'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - OPQ_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!full || rd_en))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> valid)
    else $error("command queue read while empty");

endmodule
`default_nettype wire

FILE: hdl/pmq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned multi-queue back end
// Carries out classified commands on the shared store, one store access per
// cycle while the result queue has room, and buffers the results for the receiver.
// ----------------------------------------------------------------------------
module pmq_back import pmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  pmq_op_t              op,
  output logic                 op_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [DATA_BITS-1:0] item_out,
  output logic                 last
);

  typedef struct packed {
    status_t              status;
    logic [DATA_BITS-1:0] item;
    logic                 last;
  } pmq_res_t;

  logic                     busy;
  logic [ADDR_BITS-1:0]     cur_addr;
  logic [CNT_BITS-1:0]      remain;

  logic                     credit;
  logic                     issue;
  logic                     ram_wr;
  logic                     ram_rd;
  logic [ADDR_BITS-1:0]     rd_addr;
  logic                     iss_last;
  logic                     iss_rd;
  status_t                  iss_status;
  logic [ITEM_BITS-1:0]     ram_rd_data;

  logic                     s_valid;
  logic                     s_last;
  logic                     s_rd;
  status_t                  s_status;

  pmq_res_t                 res_q [RESQ_DEPTH];
  logic [RESQ_PTR_BITS-1:0] res_wr_ptr;
  logic [RESQ_PTR_BITS-1:0] res_rd_ptr;
  logic [RESQ_CNT_BITS-1:0] res_count;
  logic                     res_pop;

  pmq_ram #(
    .WIDTH(ITEM_BITS),
    .DEPTH(TOTAL_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (op.addr),
    .wr_data (op.data),
    .rd_en   (ram_rd),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    credit     = (int'(res_count) + int'(s_valid)) < RESQ_DEPTH;
    issue      = 1'b0;
    op_pop     = 1'b0;
    ram_wr     = 1'b0;
    ram_rd     = 1'b0;
    rd_addr    = cur_addr;
    iss_last   = 1'b0;
    iss_rd     = 1'b0;
    iss_status = ST_OK;
    if (credit) begin
      if (busy) begin
        issue    = 1'b1;
        ram_rd   = 1'b1;
        iss_rd   = 1'b1;
        iss_last = remain == CNT_BITS'(1);
      end else if (op_valid) begin
        op_pop = 1'b1;
        issue  = 1'b1;
        if (op.rd) begin
          ram_rd   = 1'b1;
          rd_addr  = op.addr;
          iss_rd   = 1'b1;
          iss_last = op.cnt == CNT_BITS'(1);
        end else begin
          ram_wr     = op.wr;
          iss_last   = 1'b1;
          iss_status = op.status;
        end
      end
    end
  end

  assign res_pop  = pop && (res_count != '0);
  assign empty    = res_count == '0;
  assign status   = res_q[res_rd_ptr].status;
  assign item_out = res_q[res_rd_ptr].item;
  assign last     = res_q[res_rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      s_valid    <= 1'b0;
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      s_valid <= issue;
      if (credit && busy) begin
        if (remain == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end else if (credit && op_valid && op.rd && (op.cnt != CNT_BITS'(1))) begin
        busy <= 1'b1;
      end
      if (s_valid) begin
        res_wr_ptr <= (int'(res_wr_ptr) == RESQ_DEPTH - 1) ?
                      '0 : res_wr_ptr + RESQ_PTR_BITS'(1);
      end
      if (res_pop) begin
        res_rd_ptr <= (int'(res_rd_ptr) == RESQ_DEPTH - 1) ?
                      '0 : res_rd_ptr + RESQ_PTR_BITS'(1);
      end
      if (s_valid && !res_pop) begin
        res_count <= res_count + RESQ_CNT_BITS'(1);
      end else if (res_pop && !s_valid) begin
        res_count <= res_count - RESQ_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s_last   <= iss_last;
    s_rd     <= iss_rd;
    s_status <= iss_status;
    if (credit && busy) begin
      cur_addr <= cur_addr + ADDR_BITS'(1);
      remain   <= remain - CNT_BITS'(1);
    end else if (credit && op_valid && op.rd) begin
      cur_addr <= op.addr + ADDR_BITS'(1);
      remain   <= op.cnt - CNT_BITS'(1);
    end
    if (s_valid) begin
      res_q[res_wr_ptr].status <= s_status;
      res_q[res_wr_ptr].item   <= s_rd ? DATA_BITS'(ram_rd_data) : '0;
      res_q[res_wr_ptr].last   <= s_last;
    end
  end

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> (int'(res_count) < RESQ_DEPTH))
    else $error("result arrived with no room in the result queue");

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remain != '0))
    else $error("list run active with no words left");

  a_busy_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(op_pop))
    else $error("list run started without taking a command");

endmodule
`default_nettype wire

FILE: hdl/partitioned_multi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned multi-queue
// Four linear FIFO queues sharing one 32-word store, eight words per queue.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port: a transaction is taken when push
// is high and full is low. Mode selects enqueue, dequeue or list, and
// queue_index selects the queue; mode 3 is dropped without a result.
// Results leave through a second queue-style port: the oldest result is shown
// while empty is low and is taken when pop is high. last marks the final
// result of a command.
// The first result of a command passes the command queue, the store read
// stage and the result queue. Enqueue and dequeue each take one store access,
// so one such command per cycle is sustained while results are popped. A list
// reads the store once per word it emits, up to eight words.
// A two-entry command queue and a four-entry result queue sit between the
// front and the back; when the receiver stops popping, the result queue fills,
// the back end stops and full rises once the command queue is full.
// Reset returns every queue to empty with its pointers at the segment start;
// the store keeps its contents, which are never read before being written.
// ----------------------------------------------------------------------------
module partitioned_multi_queue import pmq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [QIDX_BITS-1:0] queue_index,
  input  logic [DATA_BITS-1:0] item,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [DATA_BITS-1:0] item_out,
  output logic                 last
);

  logic    fe_push;
  pmq_op_t fe_op;
  logic    opq_valid;
  logic    opq_pop;
  pmq_op_t opq_op;

  pmq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .mode        (mode),
    .queue_index (queue_index),
    .item        (item),
    .op_full     (full),
    .op_push     (fe_push),
    .op          (fe_op)
  );

  pmq_op_queue u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (fe_push),
    .wr_op (fe_op),
    .full  (full),
    .valid (opq_valid),
    .rd_en (opq_pop),
    .rd_op (opq_op)
  );

  pmq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (opq_valid),
    .op       (opq_op),
    .op_pop   (opq_pop),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .item_out (item_out),
    .last     (last)
  );

endmodule
`default_nettype wire
